/* hw/rtl/ckb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckb_pkg
// Shared types, constants and helpers for the ChaCha keystream block.
// ----------------------------------------------------------------------------
package ckb_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned NUM_WORDS = 16;
  localparam int unsigned IDX_W     = 4;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RND_W     = 5;
  localparam int unsigned STEP_W    = 2;

  typedef logic [WORD_W-1:0] word_t;

  // ChaCha "expand 32-byte k" constants
  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  // Rotation amounts of the four quarter-round steps
  localparam int unsigned ROT_S0 = 16;
  localparam int unsigned ROT_S1 = 12;
  localparam int unsigned ROT_S2 = 8;
  localparam int unsigned ROT_S3 = 7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_01    = 3'd0,
    CFG_KEY_23    = 3'd1,
    CFG_KEY_45    = 3'd2,
    CFG_KEY_67    = 3'd3,
    CFG_NONCE_01  = 3'd4,
    CFG_NONCE_2   = 3'd5,
    CFG_ROUND_CODE = 3'd6
  } cfg_reg_e;

  // Round count codes
  localparam logic [1:0] RC_8  = 2'd0;
  localparam logic [1:0] RC_12 = 2'd1;
  localparam logic [1:0] RC_20 = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ROUND = 2'd1,
    ST_OUT   = 2'd2
  } seq_state_t;

  // Held configuration
  typedef struct packed {
    logic [7:0][WORD_W-1:0] key;
    logic [2:0][WORD_W-1:0] nonce;
    logic [1:0]             round_code;
  } cfg_t;

  // Sequencer to datapath controls
  typedef struct packed {
    logic              load;      // capture counter and start state
    logic              round_en;  // apply one quarter-round step on all lanes
    logic [STEP_W-1:0] step;      // which line of the quarter round
    logic              diag;      // diagonal round when set
    logic              out_load;  // move the next word into the output register
    logic [IDX_W-1:0]  out_idx;   // index of that word
  } ctrl_t;

  // Index of the final round for a round code (unknown code runs 20)
  function automatic logic [RND_W-1:0] last_round(input logic [1:0] code);
    logic [RND_W-1:0] r;
    begin
      case (code)
        RC_8:    r = 5'd7;
        RC_12:   r = 5'd11;
        default: r = 5'd19;
      endcase
      return r;
    end
  endfunction

  // Starting state word at a given position
  function automatic word_t init_word(input cfg_t cfg, input word_t ctr,
                                      input logic [IDX_W-1:0] idx);
    word_t w;
    begin
      case (idx)
        4'd0:    w = SIGMA0;
        4'd1:    w = SIGMA1;
        4'd2:    w = SIGMA2;
        4'd3:    w = SIGMA3;
        4'd4:    w = cfg.key[0];
        4'd5:    w = cfg.key[1];
        4'd6:    w = cfg.key[2];
        4'd7:    w = cfg.key[3];
        4'd8:    w = cfg.key[4];
        4'd9:    w = cfg.key[5];
        4'd10:   w = cfg.key[6];
        4'd11:   w = cfg.key[7];
        4'd12:   w = ctr;
        4'd13:   w = cfg.nonce[0];
        4'd14:   w = cfg.nonce[1];
        default: w = cfg.nonce[2];
      endcase
      return w;
    end
  endfunction

endpackage

/* hw/rtl/ckb_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckb_cfg_regs
// Write-only configuration registers: key, nonce and round count code.
// ----------------------------------------------------------------------------
module ckb_cfg_regs
  import ckb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_t                 cfg
);

  // Decode the write; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key        <= '0;
      cfg.nonce      <= '0;
      cfg.round_code <= RC_20;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_01: begin
          cfg.key[0] <= cfg_data[31:0];
          cfg.key[1] <= cfg_data[63:32];
        end
        CFG_KEY_23: begin
          cfg.key[2] <= cfg_data[31:0];
          cfg.key[3] <= cfg_data[63:32];
        end
        CFG_KEY_45: begin
          cfg.key[4] <= cfg_data[31:0];
          cfg.key[5] <= cfg_data[63:32];
        end
        CFG_KEY_67: begin
          cfg.key[6] <= cfg_data[31:0];
          cfg.key[7] <= cfg_data[63:32];
        end
        CFG_NONCE_01: begin
          cfg.nonce[0] <= cfg_data[31:0];
          cfg.nonce[1] <= cfg_data[63:32];
        end
        CFG_NONCE_2: begin
          cfg.nonce[2] <= cfg_data[31:0];
        end
        CFG_ROUND_CODE: begin
          cfg.round_code <= cfg_data[1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

/* hw/rtl/ckb_qr_step.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckb_qr_step
// One line of the ChaCha quarter round: p += q; r ^= p; r <<<= s.
// ----------------------------------------------------------------------------
module ckb_qr_step
  import ckb_pkg::*;
(
  input  word_t             p,
  input  word_t             q,
  input  word_t             r,
  input  logic [STEP_W-1:0] step,
  output word_t             p_out,
  output word_t             r_out
);

  word_t sum;
  word_t mix;

  // Add and mix
  assign sum = p + q;
  assign mix = r ^ sum;

  // Rotate by the amount of this step
  always_comb begin
    case (step)
      2'd0:    r_out = {mix[WORD_W-1-ROT_S0:0], mix[WORD_W-1:WORD_W-ROT_S0]};
      2'd1:    r_out = {mix[WORD_W-1-ROT_S1:0], mix[WORD_W-1:WORD_W-ROT_S1]};
      2'd2:    r_out = {mix[WORD_W-1-ROT_S2:0], mix[WORD_W-1:WORD_W-ROT_S2]};
      default: r_out = {mix[WORD_W-1-ROT_S3:0], mix[WORD_W-1:WORD_W-ROT_S3]};
    endcase
  end

  assign p_out = sum;

endmodule

/* hw/rtl/ckb_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckb_seq
// Sequencer: steps through the rounds, then drains the 16 result words.
// ----------------------------------------------------------------------------
module ckb_seq
  import ckb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       out_free,
  input  logic [1:0] round_code,
  output logic       in_stall,
  output ctrl_t      ctrl
);

  seq_state_t        state, state_next;
  logic [RND_W-1:0]  round_cnt, round_cnt_next;
  logic [STEP_W-1:0] step_cnt, step_cnt_next;
  logic [IDX_W-1:0]  out_idx, out_idx_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      round_cnt <= '0;
      step_cnt  <= '0;
      out_idx   <= '0;
    end else begin
      state     <= state_next;
      round_cnt <= round_cnt_next;
      step_cnt  <= step_cnt_next;
      out_idx   <= out_idx_next;
    end
  end

  // Next state and controls
  always_comb begin
    state_next     = state;
    round_cnt_next = round_cnt;
    step_cnt_next  = step_cnt;
    out_idx_next   = out_idx;
    in_stall       = 1'b1;
    ctrl.load      = 1'b0;
    ctrl.round_en  = 1'b0;
    ctrl.step      = step_cnt;
    ctrl.diag      = round_cnt[0];
    ctrl.out_load  = 1'b0;
    ctrl.out_idx   = out_idx;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          ctrl.load      = 1'b1;
          round_cnt_next = '0;
          step_cnt_next  = '0;
          state_next     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        ctrl.round_en = 1'b1;
        step_cnt_next = step_cnt + 1'b1;
        if (step_cnt == STEP_W'(3)) begin
          if (round_cnt == last_round(round_code)) begin
            out_idx_next = '0;
            state_next   = ST_OUT;
          end else begin
            round_cnt_next = round_cnt + 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          ctrl.out_load = 1'b1;
          out_idx_next  = out_idx + 1'b1;
          if (out_idx == IDX_W'(NUM_WORDS - 1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

/* hw/rtl/chacha_keystream_block_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha_keystream_block_top
// ChaCha block function: one request holds a block counter and yields the
// 16 keystream words of that block in order, the last one marked.
// ----------------------------------------------------------------------------
// Sequence: a load of the start state, then the rounds (8, 12 or 20) on the
//   shared quarter-round step unit, then one word per cycle out unless stalled.
// A new request is taken only once the last word has entered the output reg;
//   the round sequencer and the single step unit per lane set this.
// Reset: synchronous; control idles, key and nonce clear, rounds return to 20.
module chacha_keystream_block_top
  import ckb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_W-1:0]    block_counter,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    keystream_word,
  output logic [IDX_W-1:0]     word_index,
  output logic                 last_word
);

  cfg_t  cfg;
  ctrl_t ctrl;
  logic  out_free;
  word_t ctr;
  word_t x      [NUM_WORDS];
  word_t x_next [NUM_WORDS];

  // Lane operand selection and step results
  logic [IDX_W-1:0] p_sel [4];
  logic [IDX_W-1:0] q_sel [4];
  logic [IDX_W-1:0] r_sel [4];
  word_t            p_new [4];
  word_t            r_new [4];

  ckb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ckb_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .out_free   (out_free),
    .round_code (cfg.round_code),
    .in_stall   (in_stall),
    .ctrl       (ctrl)
  );

  assign out_free = !out_valid || !out_stall;

  // Pick column or diagonal words for each lane, and the step's operands
  always_comb begin
    logic [1:0] sh;
    logic [1:0] ln;
    logic [IDX_W-1:0] a_i, b_i, c_i, d_i;
    sh = {1'b0, ctrl.diag};
    for (int j = 0; j < 4; j++) begin
      ln  = 2'(j);
      a_i = {2'b00, ln};
      b_i = {2'b01, 2'(ln + sh)};
      c_i = {2'b10, 2'(ln + (sh << 1))};
      d_i = {2'b11, 2'(ln + sh + (sh << 1))};
      if (!ctrl.step[0]) begin
        p_sel[j] = a_i;
        q_sel[j] = b_i;
        r_sel[j] = d_i;
      end else begin
        p_sel[j] = c_i;
        q_sel[j] = d_i;
        r_sel[j] = b_i;
      end
    end
  end

  // Four lanes of the shared step unit
  for (genvar g = 0; g < 4; g++) begin : g_lane
    ckb_qr_step u_step (
      .p     (x[p_sel[g]]),
      .q     (x[q_sel[g]]),
      .r     (x[r_sel[g]]),
      .step  (ctrl.step),
      .p_out (p_new[g]),
      .r_out (r_new[g])
    );
  end

  // Next working state: load, round step, or shift toward word 0 on output
  always_comb begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      x_next[k] = x[k];
    end
    if (ctrl.load) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        x_next[k] = init_word(cfg, block_counter, IDX_W'(k));
      end
    end else if (ctrl.round_en) begin
      for (int j = 0; j < 4; j++) begin
        x_next[p_sel[j]] = p_new[j];
        x_next[r_sel[j]] = r_new[j];
      end
    end else if (ctrl.out_load) begin
      for (int k = 0; k < NUM_WORDS - 1; k++) begin
        x_next[k] = x[k + 1];
      end
    end
  end

  // Hold the working state and the request's counter
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      x[k] <= x_next[k];
    end
    if (ctrl.load) begin
      ctr <= block_counter;
    end
  end

  // Output register: feedforward add on the word now at the head
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      keystream_word <= x[0] + init_word(cfg, ctr, ctrl.out_idx);
      word_index     <= ctrl.out_idx;
      last_word      <= (ctrl.out_idx == IDX_W'(NUM_WORDS - 1));
    end
  end

  // A taken request keeps the input closed on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not closed after an accepted request");

  // The last mark goes with word 15 only
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == IDX_W'(NUM_WORDS - 1))))
    else $error("last_word does not match word_index");

  // Words are never produced while the input is open
  a_no_out_when_open: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> (!ctrl.out_load && !ctrl.round_en))
    else $error("datapath active while idle");

  // Words follow one another in order
  a_index_order: assert property (@(posedge clk) disable iff (rst)
    (ctrl.out_load && $past(ctrl.out_load) && !$past(rst))
      |-> (ctrl.out_idx == $past(ctrl.out_idx) + 1'b1))
    else $error("output word order broken");

endmodule
